FILE: rtl/core/sfr_pkg.sv
package sfr_pkg;

  localparam int WORD_W      = 16;
  localparam int OUT_CNT_W   = 32;
  localparam int COUNT_WIDTH = 32;
  localparam int CFG_ADDR_W  = 8;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 104;

  localparam logic [WORD_W-1:0] FRAME_OVERHEAD = 16'd4;

  localparam logic [WORD_W-1:0] RST_HEADER_MAGIC = 16'h0000;
  localparam logic [WORD_W-1:0] RST_MAX_LEN      = 16'd256;
  localparam logic [WORD_W-1:0] RST_CRC_POLY     = 16'h1021;
  localparam logic [WORD_W-1:0] RST_CRC_SEED     = 16'hFFFF;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_HEADER_MAGIC = 8'd0,
    REG_MAX_LEN      = 8'd1,
    REG_CRC_POLY     = 8'd2,
    REG_CRC_SEED     = 8'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_COLLECT = 2'd1,
    PH_GOOD    = 2'd2,
    PH_BAD     = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_LEN = 2'd1,
    ST_BAD_CRC = 2'd2
  } status_t;

  typedef struct packed {
    logic [WORD_W-1:0] header_magic;
    logic [WORD_W-1:0] max_payload_len;
    logic [WORD_W-1:0] crc_poly;
    logic [WORD_W-1:0] crc_seed;
  } cfg_t;

  typedef struct packed {
    status_t              status;
    logic                 frame_good;
    logic                 in_frame;
    logic [WORD_W-1:0]    command;
    logic [WORD_W-1:0]    declared_len;
    logic [OUT_CNT_W-1:0] good_frames;
    logic [OUT_CNT_W-1:0] bad_frames;
  } result_t;

endpackage

FILE: rtl/core/sfr_crc16.sv
module sfr_crc16 (
  input  logic [sfr_pkg::WORD_W-1:0] crc_in,
  input  logic [sfr_pkg::WORD_W-1:0] word,
  input  logic [sfr_pkg::WORD_W-1:0] poly,
  output logic [sfr_pkg::WORD_W-1:0] crc_out
);

  // Word-at-a-time MSB-first CRC: fold the word in, then sixteen shift steps.
  always_comb begin
    logic [sfr_pkg::WORD_W-1:0] c;
    c = crc_in ^ word;
    for (int b = 0; b < sfr_pkg::WORD_W; b++) begin
      if (c[sfr_pkg::WORD_W-1]) begin
        c = {c[sfr_pkg::WORD_W-2:0], 1'b0} ^ poly;
      end else begin
        c = {c[sfr_pkg::WORD_W-2:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

FILE: rtl/core/sfr_engine.sv
module sfr_engine #(
  parameter int COUNT_WIDTH = sfr_pkg::COUNT_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic [sfr_pkg::WORD_W-1:0] word,
  input  sfr_pkg::cfg_t              cfg,
  output sfr_pkg::result_t           result
);

  sfr_pkg::phase_t              phase_r, phase_nxt;
  logic [sfr_pkg::WORD_W-1:0]   pos_r, pos_nxt;
  logic [sfr_pkg::WORD_W-1:0]   total_r, total_nxt;
  logic [sfr_pkg::WORD_W-1:0]   cmd_r, cmd_nxt;
  logic [sfr_pkg::WORD_W-1:0]   len_r, len_nxt;
  logic [sfr_pkg::WORD_W-1:0]   crc_r, crc_nxt;
  logic [COUNT_WIDTH-1:0]       good_cnt_r, good_cnt_nxt;
  logic [COUNT_WIDTH-1:0]       bad_cnt_r, bad_cnt_nxt;

  logic [sfr_pkg::WORD_W-1:0]   crc_base;
  logic [sfr_pkg::WORD_W-1:0]   crc_upd;
  logic [sfr_pkg::WORD_W-1:0]   last_pos;
  sfr_pkg::status_t             status_c;
  logic                         good_c;

  // Outside a frame the CRC restarts from the seed.
  assign crc_base = (phase_r == sfr_pkg::PH_COLLECT) ? crc_r : cfg.crc_seed;
  assign last_pos = total_r - 16'd1;

  sfr_crc16 u_crc (
    .crc_in  (crc_base),
    .word    (word),
    .poly    (cfg.crc_poly),
    .crc_out (crc_upd)
  );

  // Next state
  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    total_nxt    = total_r;
    cmd_nxt      = cmd_r;
    len_nxt      = len_r;
    crc_nxt      = crc_r;
    good_cnt_nxt = good_cnt_r;
    bad_cnt_nxt  = bad_cnt_r;
    status_c     = sfr_pkg::ST_OK;
    good_c       = 1'b0;
    if (phase_r != sfr_pkg::PH_COLLECT) begin
      if (word == cfg.header_magic) begin
        phase_nxt = sfr_pkg::PH_COLLECT;
        pos_nxt   = 16'd1;
        total_nxt = '0;
        cmd_nxt   = '0;
        len_nxt   = '0;
        crc_nxt   = crc_upd;
      end
    end else if (pos_r == 16'd1) begin
      cmd_nxt = word;
      crc_nxt = crc_upd;
      pos_nxt = 16'd2;
    end else if (pos_r == 16'd2) begin
      len_nxt = word;
      if (word > cfg.max_payload_len) begin
        phase_nxt   = sfr_pkg::PH_BAD;
        status_c    = sfr_pkg::ST_BAD_LEN;
        bad_cnt_nxt = (&bad_cnt_r) ? bad_cnt_r : bad_cnt_r + 1'b1;
      end else begin
        total_nxt = sfr_pkg::FRAME_OVERHEAD + word;
        crc_nxt   = crc_upd;
        pos_nxt   = 16'd3;
      end
    end else if (pos_r < last_pos) begin
      crc_nxt = crc_upd;
      pos_nxt = pos_r + 16'd1;
    end else begin
      pos_nxt = pos_r + 16'd1;
      if (crc_r == word) begin
        phase_nxt    = sfr_pkg::PH_GOOD;
        good_c       = 1'b1;
        good_cnt_nxt = (&good_cnt_r) ? good_cnt_r : good_cnt_r + 1'b1;
      end else begin
        phase_nxt   = sfr_pkg::PH_BAD;
        status_c    = sfr_pkg::ST_BAD_CRC;
        bad_cnt_nxt = (&bad_cnt_r) ? bad_cnt_r : bad_cnt_r + 1'b1;
      end
    end
  end

  // Result for this word
  always_comb begin
    result.status       = status_c;
    result.frame_good   = good_c;
    result.in_frame     = (phase_nxt == sfr_pkg::PH_COLLECT);
    result.command      = cmd_nxt;
    result.declared_len = len_nxt;
    result.good_frames  = sfr_pkg::OUT_CNT_W'(good_cnt_nxt);
    result.bad_frames   = sfr_pkg::OUT_CNT_W'(bad_cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= sfr_pkg::PH_IDLE;
      pos_r      <= '0;
      total_r    <= '0;
      cmd_r      <= '0;
      len_r      <= '0;
      crc_r      <= '0;
      good_cnt_r <= '0;
      bad_cnt_r  <= '0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      total_r    <= total_nxt;
      cmd_r      <= cmd_nxt;
      len_r      <= len_nxt;
      crc_r      <= crc_nxt;
      good_cnt_r <= good_cnt_nxt;
      bad_cnt_r  <= bad_cnt_nxt;
    end
  end

endmodule

FILE: rtl/core/spi_frame_recognizer_crc16_top.sv
// Channel  | Dir | Ports                          | Contents
// ---------+-----+--------------------------------+---------------------------------------
// in_      | in  | in_tvalid/in_tready/in_tdata   | 16-bit SPI word seen on the wire
// out_     | out | out_tvalid/out_tready/out_tdata| one status transaction per input word
// cfg_     | in  | cfg_we/cfg_addr/cfg_wdata      | register write, no read-back
//
// One word per clock sustained while out_tready stays high. A word is captured in
// the input register, runs combinationally through the frame FSM and the unrolled
// CRC-16 and lands in the output register once the output slot is free or draining;
// its result is then valid on the output and is taken when out_tready is high.
// Reset (synchronous, rst_n low) clears the FSM and the counters and returns
// the registers to their defaults. When out_tready is low the output holds;
// the input register then fills and in_tready drops until the output drains.
module spi_frame_recognizer_crc16_top #(
  parameter int COUNT_WIDTH = sfr_pkg::COUNT_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: bus_word[15:0]
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sfr_pkg::IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: status[1:0], frame_good[2], in_frame[3], command[19:4],
  //            declared_len[35:20], good_frames[67:36], bad_frames[99:68], zero[103:100]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sfr_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_we,
  input  logic [sfr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [sfr_pkg::WORD_W-1:0]      cfg_wdata
);

  sfr_pkg::cfg_t              cfg_r;
  logic                       s1_valid_r, s1_valid_nxt;
  logic [sfr_pkg::WORD_W-1:0] s1_word_r;
  logic                       out_valid_r, out_valid_nxt;
  sfr_pkg::result_t           out_res_r;
  sfr_pkg::result_t           res;
  logic                       in_accept;
  logic                       s1_adv;

  // Advance the captured word whenever the output slot is free or draining.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_accept = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_adv ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_magic    <= sfr_pkg::RST_HEADER_MAGIC;
      cfg_r.max_payload_len <= sfr_pkg::RST_MAX_LEN;
      cfg_r.crc_poly        <= sfr_pkg::RST_CRC_POLY;
      cfg_r.crc_seed        <= sfr_pkg::RST_CRC_SEED;
    end else if (cfg_we) begin
      // Drop writes to unknown indexes.
      case (cfg_addr)
        sfr_pkg::REG_HEADER_MAGIC: cfg_r.header_magic    <= cfg_wdata;
        sfr_pkg::REG_MAX_LEN:      cfg_r.max_payload_len <= cfg_wdata;
        sfr_pkg::REG_CRC_POLY:     cfg_r.crc_poly        <= cfg_wdata;
        sfr_pkg::REG_CRC_SEED:     cfg_r.crc_seed        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_word_r <= in_tdata;
    end
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  sfr_engine #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (s1_adv),
    .word   (s1_word_r),
    .cfg    (cfg_r),
    .result (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000,
                       out_res_r.bad_frames,
                       out_res_r.good_frames,
                       out_res_r.declared_len,
                       out_res_r.command,
                       out_res_r.in_frame,
                       out_res_r.frame_good,
                       out_res_r.status};

endmodule
